>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks, removed from synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ERM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ERM_ASSERT_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("forbidden condition seen");
`else
`define ERM_ASSERT(lbl, clk, rstn, prop)
`define ERM_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

>>> sv/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// shared types and constants of the echo range median filter
// ----------------------------------------------------------------------------
`default_nettype none

package erm_pkg;

    localparam int TIME_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SCALE_FRAC = 16;

    typedef logic [TIME_W-1:0] tick_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ECHO    = 2'd0,
        CFG_VALID_LIMIT = 2'd1,
        CFG_CM_SCALE    = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] MAX_ECHO_RST    = 16'd4000;
    localparam logic [CFG_W-1:0] VALID_LIMIT_RST = 16'd1000;
    localparam logic [CFG_W-1:0] CM_SCALE_RST    = 16'd11141;

    // half an output lsb, in the q16.16 product
    localparam logic [TIME_W+CFG_W:0] ROUND_HALF = 33'd32768;

    typedef struct packed {
        tick_t filt;
        logic  accepted;
        logic  updated;
    } erm_result_t;

endpackage

`default_nettype wire

>>> sv/erm_median.sv
// ----------------------------------------------------------------------------
// erm_median
// rank-select median of a small window, ties broken by position
// ----------------------------------------------------------------------------
`default_nettype none

module erm_median
    import erm_pkg::*;
#(
    parameter int WINDOW = 5
)
(
    input  wire logic [WINDOW-1:0][TIME_W-1:0] vals,
    output logic      [TIME_W-1:0]             median,
    output logic      [WINDOW-1:0]             hit
);

    localparam int RANK_W = $clog2(WINDOW);
    localparam int MID    = WINDOW / 2;

    logic [WINDOW-1:0][RANK_W-1:0] rank;

    // each value's rank is the count of values that sort before it
    always_comb
    begin
        median = '0;
        hit    = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if (j != i && ((vals[j] < vals[i]) || (vals[j] == vals[i] && j < i)))
                begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
            if (rank[i] == RANK_W'(MID))
            begin
                median = vals[i];
                hit[i] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/echo_range_median_filter.sv
// path: a result word is presented at the outputs once its falling-edge word
//   has passed the input register, filter stage and scale stage
// throughput: one echo word per cycle while the result side does not stall; rising edges give no result word
// the filter stage reads the pulse, distance and ring state and writes it back in the
//   same cycle, so back-to-back words see each other's updates
// reset: asynchronous, clears the valid flags and filter state and loads the register defaults
`default_nettype none

`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// echo_range_median_filter
// pulse width from echo edges, timeout reject, median-of-window filter capped at the newest
// distance, and q0.16 conversion to centimetres
// ----------------------------------------------------------------------------
module echo_range_median_filter
    import erm_pkg::*;
#(
    parameter int WINDOW = 5
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,

    input  wire logic                 echo_valid,
    output logic                      echo_stall,
    input  wire logic                 echo_level,
    input  wire logic [TIME_W-1:0]    edge_time,

    output logic                      dist_valid,
    input  wire logic                 dist_stall,
    output logic      [TIME_W-1:0]    distance_cm,
    output logic                      pulse_accepted,
    output logic                      filter_updated
);

    localparam int RING_DEPTH = WINDOW - 1;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // configuration
    logic [CFG_W-1:0] max_echo_reg;
    logic [CFG_W-1:0] valid_limit_reg;
    logic [CFG_W-1:0] cm_scale_reg;

    // input register
    logic  in_valid_reg;
    logic  in_level_reg;
    tick_t in_time_reg;

    // filter state
    tick_t                          pulse_start_reg;
    tick_t                          last_dist_reg;
    tick_t                          filtered_reg;
    logic [RING_DEPTH-1:0][TIME_W-1:0] ring_reg;
    logic [SLOT_W-1:0]              slot_reg;
    logic [SLOT_W-1:0]              slot_next;

    // filter stage result
    logic        s1_valid_reg;
    erm_result_t s1_reg;
    erm_result_t s1_next;

    // output register
    logic  out_valid_reg;
    tick_t dist_cm_reg;
    logic  accepted_reg;
    logic  updated_reg;

    logic out_ready;
    logic s1_ready;
    logic s0_ready;
    logic fire;
    logic fall_fire;

    tick_t width;
    logic  width_ok;
    tick_t last_new;
    logic  do_update;
    tick_t median;
    tick_t filt_new;
    logic [WINDOW-1:0][TIME_W-1:0] window;
    logic [WINDOW-1:0]             med_hit;

    logic [TIME_W+CFG_W-1:0] product;
    logic [TIME_W+CFG_W:0]   rounded;
    tick_t                   cm_next;

    // handshake
    assign out_ready  = !out_valid_reg || !dist_stall;
    assign s1_ready   = !s1_valid_reg || out_ready;
    assign s0_ready   = !in_valid_reg || s1_ready;
    assign echo_stall = !s0_ready;
    assign fire       = in_valid_reg && s1_ready;
    assign fall_fire  = fire && !in_level_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_echo_reg    <= MAX_ECHO_RST;
            valid_limit_reg <= VALID_LIMIT_RST;
            cm_scale_reg    <= CM_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_ECHO:    max_echo_reg    <= cfg_wdata;
                CFG_VALID_LIMIT: valid_limit_reg <= cfg_wdata;
                CFG_CM_SCALE:    cm_scale_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            in_valid_reg <= echo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && echo_valid)
        begin
            in_level_reg <= echo_level;
            in_time_reg  <= edge_time;
        end
    end

    // width, timeout and validity checks
    always_comb
    begin
        width     = in_time_reg - pulse_start_reg;
        width_ok  = width < max_echo_reg;
        last_new  = width_ok ? width : last_dist_reg;
        do_update = last_new < valid_limit_reg;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            window[i] = ring_reg[i];
        end
        window[WINDOW-1] = last_new;
    end

    erm_median #(
        .WINDOW (WINDOW)
    ) u_median (
        .vals   (window),
        .median (median),
        .hit    (med_hit)
    );

    always_comb
    begin
        filt_new = (last_new < median) ? last_new : median;
        if (slot_reg == SLOT_W'(RING_DEPTH - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end
        s1_next.filt     = do_update ? filt_new : filtered_reg;
        s1_next.accepted = width_ok;
        s1_next.updated  = do_update;
    end

    // filter state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_start_reg <= '0;
            last_dist_reg   <= '0;
            filtered_reg    <= '0;
            ring_reg        <= '0;
            slot_reg        <= '0;
        end
        else if (fire)
        begin
            if (in_level_reg)
            begin
                pulse_start_reg <= in_time_reg;
            end
            else
            begin
                last_dist_reg <= last_new;
                if (do_update)
                begin
                    ring_reg[slot_reg] <= last_new;
                    slot_reg           <= slot_next;
                    filtered_reg       <= filt_new;
                end
            end
        end
    end

    // filter stage result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid_reg && !in_level_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fall_fire)
        begin
            s1_reg <= s1_next;
        end
    end

    // q0.16 scale with round to nearest, saturated
    always_comb
    begin
        product = (TIME_W+CFG_W)'(s1_reg.filt) * (TIME_W+CFG_W)'(cm_scale_reg);
        rounded = {1'b0, product} + ROUND_HALF;
        if (rounded[TIME_W+CFG_W:SCALE_FRAC+TIME_W] != '0)
        begin
            cm_next = '1;
        end
        else
        begin
            cm_next = rounded[SCALE_FRAC+TIME_W-1:SCALE_FRAC];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            dist_cm_reg  <= cm_next;
            accepted_reg <= s1_reg.accepted;
            updated_reg  <= s1_reg.updated;
        end
    end

    assign dist_valid     = out_valid_reg;
    assign distance_cm    = dist_cm_reg;
    assign pulse_accepted = accepted_reg;
    assign filter_updated = updated_reg;

    // checks
    `ERM_ASSERT(a_slot_range, clk, rst_n, slot_reg <= SLOT_W'(RING_DEPTH - 1))
    `ERM_ASSERT(a_ring_move_upd, clk, rst_n, !$stable(slot_reg) |-> s1_valid_reg && s1_reg.updated)
    `ERM_ASSERT(a_empty_takes, clk, rst_n, !in_valid_reg |-> !echo_stall)
    `ERM_ASSERT(a_median_one, clk, rst_n, in_valid_reg |-> $onehot(med_hit))
    `ERM_ASSERT_NEVER(a_rise_result, clk, rst_n, $past(fire && in_level_reg) && $rose(s1_valid_reg))

endmodule

`default_nettype wire

>>> tb/tb_echo_range_median_filter.sv
// ----------------------------------------------------------------------------
// tb_echo_range_median_filter
// Drives echo edge words through the range filter and compares every result
// word with a cycle-free prediction of the pulse width, timeout reject, ring
// median and centimetre scale, across several register settings.
// ----------------------------------------------------------------------------
module tb_echo_range_median_filter
    import erm_pkg::*;
();

    // index with no register behind it, the block ignores writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    // predicts the result word of each falling edge and holds the pending ones
    class range_scoreboard;
        logic [CFG_W-1:0] max_ticks;
        logic [CFG_W-1:0] valid_lim;
        logic [CFG_W-1:0] cm_scale;
        tick_t            pulse_start;
        tick_t            last_dist;
        tick_t            filt_dist;
        tick_t            ring[4];
        logic [1:0]       slot;
        erm_result_t      expected_dist[$];
        int               errors;
        int               checked;
        int               n_updates;
        int               n_rejects;

        function new();
            max_ticks   = MAX_ECHO_RST;
            valid_lim   = VALID_LIMIT_RST;
            cm_scale    = CM_SCALE_RST;
            pulse_start = '0;
            last_dist   = '0;
            filt_dist   = '0;
            foreach (ring[i])
                ring[i] = '0;
            slot      = '0;
            errors    = 0;
            checked   = 0;
            n_updates = 0;
            n_rejects = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MAX_ECHO:    max_ticks = val;
                CFG_VALID_LIMIT: valid_lim = val;
                CFG_CM_SCALE:    cm_scale  = val;
                default: ;
            endcase
        endfunction

        function void note_echo(logic level, tick_t t);
            tick_t            width;
            tick_t            win[5];
            tick_t            tmp;
            tick_t            med;
            logic [32:0]      prod;
            erm_result_t      res;
            if (level)
            begin
                pulse_start = t;
                return;
            end
            width = t - pulse_start;
            res.accepted = (width < max_ticks);
            if (res.accepted)
                last_dist = width;
            else
                n_rejects++;
            res.updated = (last_dist < valid_lim);
            if (res.updated)
            begin
                for (int i = 0; i < 4; i++)
                    win[i] = ring[i];
                win[4] = last_dist;
                ring[slot] = last_dist;
                slot = slot + 2'd1;
                // plain exchange sort of the five window entries
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4 - i; j++)
                        if (win[j] > win[j+1])
                        begin
                            tmp      = win[j];
                            win[j]   = win[j+1];
                            win[j+1] = tmp;
                        end
                med = win[2];
                filt_dist = (last_dist < med) ? last_dist : med;
                n_updates++;
            end
            prod = 33'(filt_dist) * 33'(cm_scale) + 33'd32768;
            res.filt = prod[32] ? 16'hFFFF : prod[31:16];
            expected_dist.push_back(res);
        endfunction

        function void check_dist(tick_t cm, logic acc, logic upd);
            erm_result_t want;
            if (expected_dist.size() == 0)
            begin
                $error("result word with no prediction pending: distance_cm=%0d", cm);
                errors++;
                return;
            end
            want = expected_dist.pop_front();
            checked++;
            if (cm !== want.filt)
            begin
                $error("distance_cm: expected %0d, got %0d", want.filt, cm);
                errors++;
            end
            if (acc !== want.accepted)
            begin
                $error("pulse_accepted: expected %0d, got %0d", want.accepted, acc);
                errors++;
            end
            if (upd !== want.updated)
            begin
                $error("filter_updated: expected %0d, got %0d", want.updated, upd);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 echo_valid;
    logic                 echo_stall;
    logic                 echo_level;
    logic [TIME_W-1:0]    edge_time;
    logic                 dist_valid;
    logic                 dist_stall;
    logic [TIME_W-1:0]    distance_cm;
    logic                 pulse_accepted;
    logic                 filter_updated;

    range_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    int hold_cycles;
    int words_sent;
    int reg_writes;

    echo_range_median_filter uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .echo_valid     (echo_valid),
        .echo_stall     (echo_stall),
        .echo_level     (echo_level),
        .edge_time      (edge_time),
        .dist_valid     (dist_valid),
        .dist_stall     (dist_stall),
        .distance_cm    (distance_cm),
        .pulse_accepted (pulse_accepted),
        .filter_updated (filter_updated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && dist_valid && !dist_stall)
            sb.check_dist(distance_cm, pulse_accepted, filter_updated);
    end

    // result side: random hold-off after each word, or one long hold on request
    initial
    begin
        int n;
        dist_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
                dist_stall <= 1'b1;
                repeat (n) @(posedge clk);
                dist_stall <= 1'b0;
            end
            else if (rst_n && dist_valid && !dist_stall)
            begin
                n = rx_idle ? $urandom_range(0, 16) : 0;
                if (n > 0)
                begin
                    dist_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    dist_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_echo(logic level, tick_t t);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            echo_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        echo_valid <= 1'b1;
        echo_level <= level;
        edge_time  <= t;
        @(posedge clk);
        while (echo_stall)
            @(posedge clk);
        sb.note_echo(level, t);
        words_sent++;
    endtask

    task automatic send_pulse(tick_t start, tick_t width);
        send_echo(1'b1, start);
        send_echo(1'b0, start + width);
    endtask

    // rising edges give no result word, so allow for the pipeline after the last one
    task automatic wait_idle();
        echo_valid <= 1'b0;
        while (sb.expected_dist.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_regs(logic [CFG_W-1:0] mx, logic [CFG_W-1:0] vl, logic [CFG_W-1:0] sc);
        write_reg(CFG_MAX_ECHO, mx);
        write_reg(CFG_VALID_LIMIT, vl);
        write_reg(CFG_CM_SCALE, sc);
    endtask

    // mostly well-formed pulses with widths aimed at the two limits, plus stray edges
    task automatic random_phase(int n_words);
        int    stop_at;
        tick_t s;
        tick_t w;
        tick_t lim;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            if ((words_sent % 40) < 2)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            s = tick_t'($urandom);
            lim = (sb.max_ticks < sb.valid_lim) ? sb.max_ticks : sb.valid_lim;
            case ($urandom_range(0, 5))
                0, 1: w = (lim != 0) ? tick_t'($urandom_range(0, lim - 1)) : '0;
                2:    w = (sb.max_ticks != 0) ? tick_t'($urandom_range(0, sb.max_ticks - 1)) : '0;
                3:    w = sb.max_ticks + tick_t'($urandom_range(0, 2)) - 16'd1;
                4:    w = sb.valid_lim + tick_t'($urandom_range(0, 2)) - 16'd1;
                default: w = tick_t'($urandom);
            endcase
            case ($urandom_range(0, 99)) inside
                [0:7]:
                    send_echo(1'b0, tick_t'($urandom));
                [8:13]:
                begin
                    send_echo(1'b1, tick_t'($urandom));
                    send_pulse(s, w);
                end
                default:
                    send_pulse(s, w);
            endcase
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] mx;
        logic [CFG_W-1:0] vl;
        logic [CFG_W-1:0] sc;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_MAX_ECHO;
        cfg_wdata   = '0;
        echo_valid  = 1'b0;
        echo_level  = 1'b0;
        edge_time   = '0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_cycles = 0;
        words_sent  = 0;
        reg_writes  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed edges on the reset register values
        send_echo(1'b0, 16'd100);          // falling edge with no rising edge since reset
        send_pulse(16'd0, 16'hFFFF);       // widest pulse, rejected
        send_pulse(16'hFFFF, 16'd6);       // time stamp wraps
        send_echo(1'b1, 16'd10);           // second rising edge overwrites the start
        send_pulse(16'd20, 16'd30);
        send_pulse(16'd1000, 16'd3999);    // just under the timeout, above the valid limit
        send_pulse(16'd0, 16'd4000);       // at the timeout
        send_pulse(16'd7, 16'd999);
        send_pulse(16'd7, 16'd1000);
        send_pulse(16'd2, 16'd500);
        send_pulse(16'd0, 16'd5000);       // rejected, old distance refills the ring
        wait_idle();
        write_reg(CFG_NO_REG, 16'hFFFF);
        set_regs(16'd0, 16'd0, CM_SCALE_RST);
        send_pulse(16'd0, 16'd0);          // zero limits reject everything
        wait_idle();
        set_regs(16'd1, 16'hFFFF, 16'hFFFF);
        send_pulse(16'd9, 16'd0);
        send_pulse(16'h5555, 16'd0);
        wait_idle();

        // receiver holds off for long while edges keep coming
        tx_idle = 1'b0;
        set_regs(MAX_ECHO_RST, VALID_LIMIT_RST, CM_SCALE_RST);
        hold_cycles = 300;
        repeat (30)
            send_pulse(tick_t'($urandom), tick_t'($urandom_range(0, 1500)));
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin mx = MAX_ECHO_RST; vl = VALID_LIMIT_RST; sc = CM_SCALE_RST; end
                1: begin mx = 16'hFFFF;     vl = 16'hFFFF;        sc = 16'hFFFF;     end
                2: begin mx = 16'd1;        vl = 16'd1;           sc = 16'd0;        end
                3: begin mx = 16'd2000;     vl = 16'd300;         sc = 16'h8000;     end
                default:
                begin
                    mx = CFG_W'($urandom_range(1, 65535));
                    vl = CFG_W'($urandom_range(1, 65535));
                    sc = CFG_W'($urandom);
                end
            endcase
            set_regs(mx, vl, sc);
            random_phase(225);
            wait_idle();
        end

        $display("%0d echo words sent, %0d result words checked over %0d register writes",
                 words_sent, sb.checked, reg_writes);
        $display("%0d filter updates, %0d pulses past the timeout", sb.n_updates, sb.n_rejects);
        if (sb.errors == 0 && sb.expected_dist.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
